// ----- rtl/core/pngacs_pkg.sv -----
`default_nettype none
// ============================================================================
// PNG animation chunk scanner package
// Shared verdict codes, chunk type codes, signature table and result struct.
// ============================================================================
package pngacs_pkg;

    typedef logic [1:0] verdict_t;

    localparam verdict_t VERDICT_NOT_PNG  = 2'd0;
    localparam verdict_t VERDICT_STILL    = 2'd1;
    localparam verdict_t VERDICT_ANIMATED = 2'd2;

    localparam logic [31:0] TYPE_ACTL = 32'h6163544C;
    localparam logic [31:0] TYPE_IDAT = 32'h49444154;
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;

    // Result of one accepted byte, passed from the scanner to the output queue.
    typedef struct packed {
        logic     valid;
        verdict_t verdict;
        logic     at_file_start;
    } scan_result_t;

    // The eight bytes of the PNG file signature.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pngacs_channels.sv -----
`default_nettype none
// ============================================================================
// PNG animation chunk scanner channels
// Valid/ready interfaces for the byte stream and the verdict stream.
// ============================================================================
interface pngacs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pngacs_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pngacs_scanner.sv -----
`default_nettype none
// ============================================================================
// PNG animation chunk scanner core
// Signature check and chunk walk, one byte per accepted transaction.
// ============================================================================
module pngacs_scanner
    import pngacs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   data_byte,
    input  wire logic         last_byte,
    output scan_result_t      result
);

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_TAIL,
        PH_SKIP,
        PH_DONE
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  count_reg,  count_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] type_reg,   type_next;
    logic [31:0] skip_reg,   skip_next;
    logic        have;
    verdict_t    verdict;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        type_next   = type_reg;
        skip_next   = skip_reg;
        have        = 1'b0;
        verdict     = VERDICT_NOT_PNG;

        unique case (phase_reg)
            PH_SIG:
            begin
                if (data_byte != sig_byte(count_reg))
                begin
                    have       = 1'b1;
                    verdict    = VERDICT_NOT_PNG;
                    phase_next = PH_DONE;
                    count_next = 3'd0;
                end
                else if (count_reg == 3'd7)
                begin
                    phase_next = PH_LEN;
                    count_next = 3'd0;
                end
                else
                begin
                    count_next = count_reg + 3'd1;
                end
            end
            PH_LEN:
            begin
                length_next = {length_reg[23:0], data_byte};
                if (count_reg == 3'd3)
                begin
                    phase_next = PH_TYPE;
                    count_next = 3'd0;
                end
                else
                begin
                    count_next = count_reg + 3'd1;
                end
            end
            PH_TYPE:
            begin
                type_next = {type_reg[23:0], data_byte};
                if (count_reg == 3'd3)
                begin
                    phase_next = PH_TAIL;
                    count_next = 3'd0;
                end
                else
                begin
                    count_next = count_reg + 3'd1;
                end
            end
            PH_TAIL:
            begin
                if (count_reg == 3'd3)
                begin
                    count_next = 3'd0;
                    if (type_reg == TYPE_ACTL)
                    begin
                        have       = 1'b1;
                        verdict    = VERDICT_ANIMATED;
                        phase_next = PH_DONE;
                    end
                    else if (type_reg == TYPE_IDAT || type_reg == TYPE_IEND)
                    begin
                        have       = 1'b1;
                        verdict    = VERDICT_STILL;
                        phase_next = PH_DONE;
                    end
                    else if (length_reg == 32'd0)
                    begin
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        skip_next  = length_reg;
                        phase_next = PH_SKIP;
                    end
                end
                else
                begin
                    count_next = count_reg + 3'd1;
                end
            end
            PH_SKIP:
            begin
                if (skip_reg != 32'd0)
                begin
                    skip_next = skip_reg - 32'd1;
                end
                if (skip_reg <= 32'd1)
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_DONE:
            begin
                // Verdict already given; bytes up to the last are ignored.
            end
            default:
            begin
            end
        endcase

        // The end of the file forces a verdict if none was given and
        // returns the scanner to the start of a new file.
        if (last_byte)
        begin
            if (!have && phase_next != PH_DONE)
            begin
                have    = 1'b1;
                verdict = (phase_next == PH_SIG) ? VERDICT_NOT_PNG : VERDICT_STILL;
            end
            phase_next  = PH_SIG;
            count_next  = 3'd0;
            length_next = 32'd0;
            type_next   = 32'd0;
            skip_next   = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            count_reg  <= 3'd0;
            length_reg <= 32'd0;
            type_reg   <= 32'd0;
            skip_reg   <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            type_reg   <= type_next;
            skip_reg   <= skip_next;
        end
    end

    assign result.valid         = accept && have;
    assign result.verdict       = verdict;
    assign result.at_file_start = (phase_reg == PH_SIG) && (count_reg == 3'd0);

endmodule
`default_nettype wire

// ----- rtl/core/pngacs_out_queue.sv -----
`default_nettype none
// ============================================================================
// PNG animation chunk scanner output queue
// Two-entry result register with skid entry between scanner and output.
// ============================================================================
module pngacs_out_queue
    import pngacs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire verdict_t push_verdict,
    input  wire logic     pop_ready,
    output logic          head_valid,
    output verdict_t      head_verdict,
    output logic          space,
    output logic          tail_busy
);

    logic     head_valid_reg, head_valid_next;
    logic     tail_valid_reg, tail_valid_next;
    verdict_t head_reg,       head_next;
    verdict_t tail_reg,       tail_next;
    logic     pop;

    assign pop = head_valid_reg && pop_ready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        if (pop)
        begin
            head_next       = tail_reg;
            head_valid_next = tail_valid_reg;
            tail_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!head_valid_next)
            begin
                head_next       = push_verdict;
                head_valid_next = 1'b1;
            end
            else
            begin
                tail_next       = push_verdict;
                tail_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign head_valid   = head_valid_reg;
    assign head_verdict = head_reg;
    assign space        = !tail_valid_reg;
    assign tail_busy    = tail_valid_reg;

endmodule
`default_nettype wire

// ----- rtl/core/png_animation_chunk_scanner.sv -----
`default_nettype none
// ============================================================================
// PNG animation chunk scanner
// Classifies each file in the byte stream as not PNG, still PNG or animated PNG.
// ============================================================================
//
// Channel          Role   Payload                  Transaction
// ---------------  -----  -----------------------  ------------------------
// byte_stream      sink   data_byte[7:0], last_byte one file byte
// verdict_stream   source verdict[1:0]             one verdict per file
//
// One byte is taken per clock cycle while the queue has room; its effect on
// the scan state is computed in the same cycle and any verdict is written
// into the output queue at that edge, in the head entry if free, else the skid.
// The two-entry output queue lets bytes keep flowing while a verdict waits;
// byte_stream.ready drops only when both queue entries are occupied.
// Reset (rst_n low, asynchronous) returns the scanner to the start of the
// signature and empties the queue. No clearing pass is needed.
//
module png_animation_chunk_scanner
    import pngacs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    pngacs_byte_if.sink        byte_stream,
    pngacs_verdict_if.source   verdict_stream
);

    logic         accept;
    logic         space;
    logic         tail_busy;
    logic         head_valid;
    verdict_t     head_verdict;
    scan_result_t scan_result;

    // A byte transaction completes when the source offers and the queue
    // still has room for a possible verdict.
    assign byte_stream.ready = space;
    assign accept            = byte_stream.valid && space;

    // Signature check and chunk walk.
    pngacs_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (byte_stream.data_byte),
        .last_byte (byte_stream.last_byte),
        .result    (scan_result)
    );

    // Result register plus skid entry toward the verdict channel.
    pngacs_out_queue u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (scan_result.valid),
        .push_verdict (scan_result.verdict),
        .pop_ready    (verdict_stream.ready),
        .head_valid   (head_valid),
        .head_verdict (head_verdict),
        .space        (space),
        .tail_busy    (tail_busy)
    );

    assign verdict_stream.valid   = head_valid;
    assign verdict_stream.verdict = head_verdict;

    // After the last byte of a file the scanner must be back at the
    // first signature byte.
    a_restart_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept && byte_stream.last_byte |=> scan_result.at_file_start
    ) else $error("scanner did not restart after last byte");

    // The skid entry is only ever filled behind a valid head entry.
    a_queue_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        tail_busy |-> head_valid
    ) else $error("output queue tail valid without head");

    // Only the three defined verdict codes leave the block.
    a_verdict_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        verdict_stream.valid |-> (verdict_stream.verdict == VERDICT_NOT_PNG ||
                                  verdict_stream.verdict == VERDICT_STILL ||
                                  verdict_stream.verdict == VERDICT_ANIMATED)
    ) else $error("undefined verdict code on output");

endmodule
`default_nettype wire
